[hdl/ffba_pkg.sv]
// shared constants, codes and types of the first-fit block allocator
package ffba_pkg;

  localparam int MAX_BLOCKS      = 4;
  localparam int BLOCK_MAX_BYTES = 1024;
  localparam int HEADER_BYTES    = 16;

  localparam int ADDR_W = 12;
  localparam int REQ_W  = 10;
  localparam int SIZE_W = 10;
  localparam int CFG_W  = 11;
  localparam int SLOT_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int OFF_W  = $clog2(BLOCK_MAX_BYTES);
  localparam int SPAN_W = $clog2(BLOCK_MAX_BYTES + 1);

  localparam logic [CFG_W-1:0] BLOCK_BYTES_RST = CFG_W'(64);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_MEM   = 2'd1;
  localparam logic [1:0] ST_DBL_FREE = 2'd2;
  localparam logic [1:0] ST_BAD_ADDR = 2'd3;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] data_address;
    logic [1:0]        status;
    logic              made_new_block;
  } ffba_result_t;

endpackage

[hdl/ffba_out_reg.sv]
// result holding register between the sequencer and the result channel
module ffba_out_reg import ffba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ffba_result_t      res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] out_data_address,
  output logic [1:0]        out_status,
  output logic              out_made_new_block
);

  logic         valid_r;
  ffba_result_t res_r;

  // slot is free when empty or being taken this cycle
  assign free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid          = valid_r;
  assign out_data_address   = res_r.data_address;
  assign out_status         = res_r.status;
  assign out_made_new_block = res_r.made_new_block;

endmodule

[hdl/first_fit_block_allocator.sv]
// top level of the first-fit block allocator: sequencer, header store, block table
//
// input channel: in_valid / in_stall with in_req_type, in_request_bytes and
// in_release_address; an item is taken when in_valid is high and in_stall low.
// in_stall is high whenever an item is being worked on; one item at a time.
// result channel: out_valid / out_stall, one result item per input item.
// a finished result sits in an output register, so the next input item is
// taken while the receiver still stalls the previous result.
// cfg_we / cfg_wdata write the default block span (block_bytes), reset 64.
// the header chain is walked through one memory port with
// registered read: each header visited passes a read state and a check
// state. an allocate also passes S_NEW when a new block is set up and
// S_SPLIT for a split; a release walks the headers before its address.
// reset clears the block count; block 0 is laid out with the first item,
// so no clearing pass of the header store is needed.
// while out_stall holds a result, a second finished result waits in the
// done state and the block takes no further item.
module first_fit_block_allocator import ffba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [REQ_W-1:0]  in_request_bytes,
  input  logic [ADDR_W-1:0] in_release_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] out_data_address,
  output logic [1:0]        out_status,
  output logic              out_made_new_block
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_ARD, S_ACHK, S_NEW, S_SPLIT, S_RRD, S_RCHK, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   block_bytes_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               type_r, type_nxt;
  logic [REQ_W-1:0]   req_r, req_nxt;
  logic [ADDR_W-1:0]  rel_r, rel_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [SPAN_W-1:0]  off_r, off_nxt;
  logic [ADDR_W-1:0]  naddr_r, naddr_nxt;
  logic [SIZE_W-1:0]  nsize_r, nsize_nxt;
  ffba_result_t       res_r, res_nxt;

  // header store: {in_use, size} per byte offset
  logic [SIZE_W:0]    hdr_mem [MAX_BLOCKS*BLOCK_MAX_BYTES];
  logic [SIZE_W:0]    rd_data_r;
  logic               rd_en, we;
  logic [ADDR_W-1:0]  rd_addr, wa;
  logic [SIZE_W:0]    wd;

  logic [SPAN_W-1:0]  span_mem [MAX_BLOCKS];
  logic               span_we;
  logic [SLOT_W-1:0]  span_wa;
  logic [SPAN_W-1:0]  span_wd;

  logic               out_free, out_load;

  // clamped default span and span needed by the request
  logic [SPAN_W-1:0]  def_span, need_span, new_span, cur_span;
  logic [CNT_W-1:0]   cnt_eff;
  logic [ADDR_W-1:0]  hdr_addr;
  logic [SIZE_W-1:0]  rd_size;
  logic               rd_use;
  logic [SPAN_W:0]    next_off;
  logic [SPAN_W:0]    want;
  logic               alloc_split, new_split;

  always_comb begin
    if (block_bytes_r < CFG_W'(HEADER_BYTES)) begin
      def_span = SPAN_W'(HEADER_BYTES);
    end else if (block_bytes_r > CFG_W'(BLOCK_MAX_BYTES)) begin
      def_span = SPAN_W'(BLOCK_MAX_BYTES);
    end else begin
      def_span = SPAN_W'(block_bytes_r);
    end
    need_span = SPAN_W'(req_r) + SPAN_W'(HEADER_BYTES + 1);
    new_span  = (need_span > def_span) ? need_span : def_span;
  end

  assign cur_span = span_mem[slot_r];
  assign hdr_addr = ADDR_W'(slot_r) * ADDR_W'(BLOCK_MAX_BYTES) + ADDR_W'(off_r);
  assign rd_size  = rd_data_r[SIZE_W-1:0];
  assign rd_use   = rd_data_r[SIZE_W];
  assign next_off = (SPAN_W+1)'(off_r) + (SPAN_W+1)'(HEADER_BYTES) + (SPAN_W+1)'(rd_size);
  assign want     = (SPAN_W+1)'(rel_r[OFF_W-1:0]);
  assign alloc_split = (SPAN_W+1)'(rd_size) > (SPAN_W+1)'(req_r) + (SPAN_W+1)'(HEADER_BYTES);
  assign new_split   = (SPAN_W+1)'(new_span) >
                       (SPAN_W+1)'(req_r) + (SPAN_W+1)'(2*HEADER_BYTES);
  assign cnt_eff  = (cnt_r == '0) ? CNT_W'(1) : cnt_r;

  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && out_free;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    type_nxt  = type_r;
    req_nxt   = req_r;
    rel_nxt   = rel_r;
    slot_nxt  = slot_r;
    off_nxt   = off_r;
    naddr_nxt = naddr_r;
    nsize_nxt = nsize_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = hdr_addr;
    we        = 1'b0;
    wa        = hdr_addr;
    wd        = rd_data_r;
    span_we   = 1'b0;
    span_wa   = slot_r;
    span_wd   = new_span;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          type_nxt  = in_req_type;
          req_nxt   = in_request_bytes;
          rel_nxt   = in_release_address;
          res_nxt   = '0;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        // lay out block 0 before the very first item
        if (cnt_r == '0) begin
          we      = 1'b1;
          wa      = '0;
          wd      = {1'b0, SIZE_W'(def_span - SPAN_W'(HEADER_BYTES))};
          span_we = 1'b1;
          span_wa = '0;
          span_wd = def_span;
          cnt_nxt = CNT_W'(1);
        end
        off_nxt = '0;
        if (type_r == REQ_ALLOC) begin
          slot_nxt  = SLOT_W'(cnt_eff - CNT_W'(1));
          state_nxt = S_ARD;
        end else begin
          slot_nxt = rel_r[ADDR_W-1 -: SLOT_W];
          if (CNT_W'(rel_r[ADDR_W-1 -: SLOT_W]) < cnt_eff) begin
            state_nxt = S_RRD;
          end else begin
            res_nxt.status = ST_BAD_ADDR;
            state_nxt      = S_DONE;
          end
        end
      end
      S_ARD: begin
        if (off_r < cur_span) begin
          rd_en     = 1'b1;
          state_nxt = S_ACHK;
        end else if (slot_r == '0) begin
          state_nxt = S_NEW;
        end else begin
          slot_nxt = slot_r - SLOT_W'(1);
          off_nxt  = '0;
        end
      end
      S_ACHK: begin
        if (!rd_use && (rd_size > SIZE_W'(req_r))) begin
          we = 1'b1;
          wd = {1'b1, alloc_split ? SIZE_W'(req_r) : rd_size};
          res_nxt.data_address = hdr_addr + ADDR_W'(HEADER_BYTES);
          naddr_nxt = hdr_addr + ADDR_W'(HEADER_BYTES) + ADDR_W'(req_r);
          nsize_nxt = rd_size - SIZE_W'(req_r) - SIZE_W'(HEADER_BYTES);
          state_nxt = alloc_split ? S_SPLIT : S_DONE;
        end else begin
          off_nxt   = SPAN_W'(next_off);
          state_nxt = S_ARD;
        end
      end
      S_NEW: begin
        if ((cnt_r >= CNT_W'(MAX_BLOCKS)) || (new_span > SPAN_W'(BLOCK_MAX_BYTES))) begin
          res_nxt.status = ST_NO_MEM;
          state_nxt      = S_DONE;
        end else begin
          // fresh block: its first variable always fits
          we      = 1'b1;
          wa      = ADDR_W'(cnt_r) * ADDR_W'(BLOCK_MAX_BYTES);
          wd      = {1'b1, new_split ? SIZE_W'(req_r)
                                     : SIZE_W'(new_span - SPAN_W'(HEADER_BYTES))};
          span_we = 1'b1;
          span_wa = SLOT_W'(cnt_r);
          span_wd = new_span;
          cnt_nxt = cnt_r + CNT_W'(1);
          res_nxt.made_new_block = 1'b1;
          res_nxt.data_address   = ADDR_W'(cnt_r) * ADDR_W'(BLOCK_MAX_BYTES)
                                   + ADDR_W'(HEADER_BYTES);
          naddr_nxt = ADDR_W'(cnt_r) * ADDR_W'(BLOCK_MAX_BYTES)
                      + ADDR_W'(HEADER_BYTES) + ADDR_W'(req_r);
          nsize_nxt = SIZE_W'(new_span - SPAN_W'(2*HEADER_BYTES) - SPAN_W'(req_r));
          state_nxt = new_split ? S_SPLIT : S_DONE;
        end
      end
      S_SPLIT: begin
        we        = 1'b1;
        wa        = naddr_r;
        wd        = {1'b0, nsize_r};
        state_nxt = S_DONE;
      end
      S_RRD: begin
        if ((off_r < cur_span) &&
            ((SPAN_W+1)'(off_r) + (SPAN_W+1)'(HEADER_BYTES) <= want)) begin
          rd_en     = 1'b1;
          state_nxt = S_RCHK;
        end else begin
          res_nxt.status = ST_BAD_ADDR;
          state_nxt      = S_DONE;
        end
      end
      S_RCHK: begin
        if ((SPAN_W+1)'(off_r) + (SPAN_W+1)'(HEADER_BYTES) == want) begin
          if (rd_use) begin
            we             = 1'b1;
            wd             = {1'b0, rd_size};
            res_nxt.status = ST_OK;
          end else begin
            res_nxt.status = ST_DBL_FREE;
          end
          state_nxt = S_DONE;
        end else begin
          off_nxt   = SPAN_W'(next_off);
          state_nxt = S_RRD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      block_bytes_r <= BLOCK_BYTES_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        block_bytes_r <= cfg_wdata;
      end
    end
    type_r  <= type_nxt;
    req_r   <= req_nxt;
    rel_r   <= rel_nxt;
    slot_r  <= slot_nxt;
    off_r   <= off_nxt;
    naddr_r <= naddr_nxt;
    nsize_r <= nsize_nxt;
    res_r   <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      hdr_mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data_r <= hdr_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (span_we) begin
      span_mem[span_wa] <= span_wd;
    end
  end

  ffba_out_reg u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (out_load),
    .res                (res_r),
    .free               (out_free),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data_address   (out_data_address),
    .out_status         (out_status),
    .out_made_new_block (out_made_new_block)
  );

endmodule
